[hdl/link_handshake_keepalive_fsm_macros.svh]
// Assertion macros used by the checker file of the link handshake block.
`ifndef LINK_HANDSHAKE_KEEPALIVE_FSM_MACROS_SVH
`define LINK_HANDSHAKE_KEEPALIVE_FSM_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define LHK_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define LHK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/lhk_pkg.sv]
// Package with types, codes and helpers of the link handshake block.
package lhk_pkg;

    // Width of the local and peer generation numbers.
    localparam int GEN_W = 32;

    // Event codes as carried in req_type.
    typedef enum logic [2:0] {
        EV_CONNECT  = 3'd0,
        EV_DISCON   = 3'd1,
        EV_INT_DISC = 3'd2,
        EV_RX_REQ   = 3'd3,
        EV_RX_ACK   = 3'd4,
        EV_RX_RST   = 3'd5,
        EV_RX_ALV   = 3'd6,
        EV_TICK     = 3'd7
    } lhk_ev_t;

    // Connection state, one-hot.
    typedef enum logic [2:0] {
        ST_DISC    = 3'b001,
        ST_CONNING = 3'b010,
        ST_CONN    = 3'b100
    } lhk_state_t;

    // Packet codes.
    localparam logic [2:0] PKT_NONE = 3'd0;
    localparam logic [2:0] PKT_REQ  = 3'd1;
    localparam logic [2:0] PKT_ACK  = 3'd2;
    localparam logic [2:0] PKT_RST  = 3'd3;
    localparam logic [2:0] PKT_ALV  = 3'd4;

    // Notice codes.
    localparam logic [1:0] NOTE_NONE = 2'd0;
    localparam logic [1:0] NOTE_UP   = 2'd1;
    localparam logic [1:0] NOTE_DOWN = 2'd2;

    // Link state codes on the result beat.
    localparam logic [1:0] LS_DISC    = 2'd0;
    localparam logic [1:0] LS_CONNING = 2'd1;
    localparam logic [1:0] LS_CONN    = 2'd2;

    // Reset value of the dead limit register.
    localparam logic [3:0] DEAD_LIMIT_RST = 4'd3;
    localparam logic [3:0] MISSED_MAX     = 4'd15;

    // Input beat.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] peer_generation;
    } lhk_in_t;

    // Result beat.
    typedef struct packed {
        logic [2:0]  send_packet;
        logic [31:0] packet_generation;
        logic [1:0]  link_notice;
        logic [1:0]  link_state;
        logic        delivery_on;
        logic        bad_request;
    } lhk_out_t;

    // One classified event as it waits in the queue.
    typedef struct packed {
        lhk_ev_t          ev;
        logic [GEN_W-1:0] peer_gen;
    } lhk_evq_t;

    // Queue head as the front presents it to the back.
    typedef struct packed {
        logic     valid;
        lhk_evq_t entry;
    } lhk_head_t;

    // Map the one-hot state to its code on the result beat.
    function automatic logic [1:0] state_code(lhk_state_t st);
        logic [1:0] code;
        unique case (st)
            ST_DISC:    code = LS_DISC;
            ST_CONNING: code = LS_CONNING;
            ST_CONN:    code = LS_CONN;
            default:    code = LS_DISC;
        endcase
        return code;
    endfunction

endpackage

[hdl/lhk_front.sv]
// Front end: accepts input beats, classifies them and queues them for the back end.
module lhk_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lhk_pkg::lhk_in_t   s_data,
    output lhk_pkg::lhk_head_t head,
    input  logic               pop
);
    import lhk_pkg::*;

    lhk_evq_t   q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       do_pop;
    lhk_evq_t   cls;

    // Classify the incoming event; the peer generation rides along and only REQ and ACK use it.
    always_comb begin
        cls.peer_gen = s_data.peer_generation[GEN_W-1:0];
        cls.ev       = lhk_ev_t'(s_data.req_type);
    end

    // Two-entry queue control.
    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign do_pop  = pop && (count_reg != 2'd0);

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

    // Head of the queue.
    assign head.valid = (count_reg != 2'd0);
    assign head.entry = q_mem[rd_ptr_reg];

endmodule

[hdl/lhk_back.sv]
// Back end: applies queued events to the link state and registers the result beat.
module lhk_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    input  lhk_pkg::lhk_head_t head,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output lhk_pkg::lhk_out_t  m_data
);
    import lhk_pkg::*;

    lhk_state_t       st_reg, st_next;
    logic [GEN_W-1:0] local_gen_reg, local_gen_next;
    logic [GEN_W-1:0] peer_gen_reg, peer_gen_next;
    logic [31:0]      attempt_reg, attempt_next;
    logic [3:0]       missed_reg, missed_next;
    logic [3:0]       dead_limit_reg;
    logic             m_valid_reg;
    lhk_out_t         m_data_reg, m_data_next;
    logic [2:0]       pkt;
    logic [1:0]       note;
    logic             bad;
    logic             go_up;
    logic             go_down;

    // Take the next event whenever the output register is free or being drained.
    assign pop = head.valid && (!m_valid_reg || m_ready);

    // Event handling.
    always_comb begin
        st_next        = st_reg;
        local_gen_next = local_gen_reg;
        peer_gen_next  = peer_gen_reg;
        attempt_next   = attempt_reg;
        missed_next    = missed_reg;
        pkt            = PKT_NONE;
        note           = NOTE_NONE;
        bad            = 1'b0;
        go_up          = 1'b0;
        go_down        = 1'b0;

        case (head.entry.ev)
            EV_CONNECT: begin
                if (st_reg == ST_DISC) begin
                    local_gen_next = local_gen_reg + 1'b1;
                    attempt_next   = attempt_reg + 32'd1;
                    missed_next    = 4'd0;
                    pkt            = PKT_REQ;
                    st_next        = ST_CONNING;
                end else begin
                    bad = 1'b1;
                end
            end
            EV_DISCON: begin
                if (st_reg == ST_CONNING) begin
                    go_down = 1'b1;
                end else if (st_reg == ST_CONN) begin
                    pkt     = PKT_RST;
                    go_down = 1'b1;
                end
            end
            EV_INT_DISC: begin
                if (st_reg == ST_CONN) begin
                    pkt     = PKT_RST;
                    go_down = 1'b1;
                end
            end
            EV_RX_REQ: begin
                if (st_reg == ST_CONNING) begin
                    pkt   = PKT_ACK;
                    go_up = 1'b1;
                end else if (st_reg == ST_CONN) begin
                    pkt     = PKT_RST;
                    go_down = 1'b1;
                end
            end
            EV_RX_ACK: begin
                go_up = (st_reg == ST_CONNING);
            end
            EV_RX_RST: begin
                go_down = (st_reg == ST_CONN);
            end
            EV_RX_ALV: begin
                if (st_reg == ST_CONN) begin
                    missed_next = 4'd0;
                end
            end
            default: begin
                // Timer tick: keepalive or dead-peer detection.
                if (st_reg == ST_CONN) begin
                    if (missed_reg >= dead_limit_reg) begin
                        pkt     = PKT_RST;
                        go_down = 1'b1;
                    end else begin
                        pkt = PKT_ALV;
                        if (missed_reg < MISSED_MAX) begin
                            missed_next = missed_reg + 4'd1;
                        end
                    end
                end
            end
        endcase

        if (go_up) begin
            missed_next   = 4'd0;
            peer_gen_next = head.entry.peer_gen;
            st_next       = ST_CONN;
            note          = NOTE_UP;
        end
        if (go_down) begin
            st_next = ST_DISC;
            note    = NOTE_DOWN;
        end

        // Result beat built from the state after the event.
        m_data_next.send_packet       = pkt;
        m_data_next.packet_generation = (pkt != PKT_NONE) ? 32'(local_gen_next) : 32'd0;
        m_data_next.link_notice       = note;
        m_data_next.link_state        = state_code(st_next);
        m_data_next.delivery_on       = (st_next == ST_CONN);
        m_data_next.bad_request       = bad;
    end

    // Link state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_DISC;
            local_gen_reg <= '0;
            peer_gen_reg  <= '0;
            attempt_reg   <= 32'd0;
            missed_reg    <= 4'd0;
        end else if (pop) begin
            st_reg        <= st_next;
            local_gen_reg <= local_gen_next;
            peer_gen_reg  <= peer_gen_next;
            attempt_reg   <= attempt_next;
            missed_reg    <= missed_next;
        end
    end

    // Dead limit configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_limit_reg <= DEAD_LIMIT_RST;
        end else if (cfg_we) begin
            dead_limit_reg <= cfg_wdata;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hdl/link_handshake_keepalive_fsm.sv]
// Link handshake and keepalive machine: one event beat in, one result beat out. Events
// are taken one per cycle while s_ready is high; each event is held in the two-entry queue
// of the front end, and the back end takes it from the queue head, updating the link state
// as it loads its output register. s_ready drops only when the queue is full because
// results are not being taken. The user writes dead_limit through cfg_we/cfg_wdata only
// while no events are in flight; the block itself does not enforce this.
module link_handshake_keepalive_fsm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [3:0]        cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  lhk_pkg::lhk_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lhk_pkg::lhk_out_t m_data
);
    import lhk_pkg::*;

    lhk_head_t head;
    logic      pop;

    // Event classification and queue.
    lhk_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .head    (head),
        .pop     (pop)
    );

    // State update and result register.
    lhk_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[hdl/lhk_checker.sv]
// Port-level checker for the link handshake block and its bind.
`include "link_handshake_keepalive_fsm_macros.svh"

module lhk_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input lhk_pkg::lhk_out_t m_data
);
    import lhk_pkg::*;

    // A stalled result beat holds.
    `LHK_ASSERT_NEXT(a_out_hold, aresetn && m_valid && !m_ready, m_valid && $stable(m_data))
    // Delivery is enabled exactly when the link is connected.
    `LHK_ASSERT_IMPL(a_delivery, m_valid,
        m_data.delivery_on == (m_data.link_state == LS_CONN))
    // A rejected connect sends nothing and changes no notice.
    `LHK_ASSERT_IMPL(a_bad_quiet, m_valid && m_data.bad_request,
        m_data.send_packet == PKT_NONE && m_data.link_notice == NOTE_NONE)
    // With no packet sent the generation field is zero.
    `LHK_ASSERT_IMPL(a_gen_zero, m_valid && m_data.send_packet == PKT_NONE,
        m_data.packet_generation == 32'd0)
    // A down notice leaves the link disconnected.
    `LHK_ASSERT_IMPL(a_down_state, m_valid && m_data.link_notice == NOTE_DOWN,
        m_data.link_state == LS_DISC)

endmodule

bind link_handshake_keepalive_fsm lhk_checker u_lhk_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
